/* design/bit_flag_change_logger_top_defines.svh */
// assertion macros for the bit flag change logger
// used by bit_flag_change_logger_top, which supplies i_clk and i_rst_n
`ifndef BIT_FLAG_CHANGE_LOGGER_TOP_DEFINES_SVH
`define BIT_FLAG_CHANGE_LOGGER_TOP_DEFINES_SVH

// condition must hold in the same cycle
`define BFCL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bit flag change logger: same cycle check failed");

// condition must hold in the next cycle
`define BFCL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bit flag change logger: next cycle check failed");

`endif

/* design/bfcl_pkg.sv */
// types, constants and helper functions of the bit flag change logger
// no dependencies; used by bfcl_ram and bit_flag_change_logger_top
`default_nettype none

package bfcl_pkg;

    localparam int DEF_RECORDS          = 4;
    localparam int DEF_WORDS_PER_RECORD = 1024;
    localparam int DEF_LOG_DEPTH        = 16;

    localparam int WORD_W    = 32;
    localparam int FLAG_W    = 15;
    localparam int REC_W     = 2;
    localparam int WIDX_W    = 10;
    localparam int POS_W     = 4;
    localparam int BIT_W     = 5;
    localparam int SHIFT_W   = 3;
    localparam int ENTRY_W   = REC_W + FLAG_W + 1;
    localparam int WCODE_W   = 2;
    localparam int CFG_REGS  = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_SEL_W = 2;

    typedef logic [WCODE_W-1:0] t_wcode;

    localparam t_wcode WCODE_8  = 2'd0;
    localparam t_wcode WCODE_16 = 2'd1;
    localparam t_wcode WCODE_32 = 2'd2;

    localparam t_wcode WCODE_RESET [CFG_REGS] = '{WCODE_32, WCODE_32, WCODE_32, WCODE_8};

    typedef enum logic [1:0] {
        FUNC_SCAN  = 2'd0,
        FUNC_UNDO  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_CHANGE = 2'd0,
        KIND_UNDO   = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_CMP,
        ST_SCAN_EMIT,
        ST_UNDO_DEC,
        ST_UNDO_RD,
        ST_UNDO_WR,
        ST_READ_OUT
    } t_state;

    typedef struct packed {
        logic [REC_W-1:0]  rec;
        logic [FLAG_W-1:0] flag;
        logic              value;
    } t_entry;

    function automatic int f_addr_w(int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // log2 of the word width
    function automatic logic [SHIFT_W-1:0] f_width_shift(t_wcode code);
        logic [SHIFT_W-1:0] sh;
        case (code)
            WCODE_8:  sh = 3'd3;
            WCODE_16: sh = 3'd4;
            default:  sh = 3'd5;
        endcase
        return sh;
    endfunction

    function automatic logic [WORD_W-1:0] f_width_mask(t_wcode code);
        logic [WORD_W-1:0] m;
        case (code)
            WCODE_8:  m = 32'h0000_00ff;
            WCODE_16: m = 32'h0000_ffff;
            default:  m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    // bit position within a word: width minus one
    function automatic logic [BIT_W-1:0] f_bit_mask(t_wcode code);
        logic [BIT_W-1:0] m;
        case (code)
            WCODE_8:  m = 5'd7;
            WCODE_16: m = 5'd15;
            default:  m = 5'd31;
        endcase
        return m;
    endfunction

    // index of the lowest set bit, zero for an empty word
    function automatic logic [BIT_W-1:0] f_lowest_bit(logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] onehot;
        logic [BIT_W-1:0]  idx;
        onehot = v & (~v + 1'b1);
        idx    = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (onehot[i]) begin
                idx = idx | BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

/* design/bfcl_ram.sv */
// generic simple dual port ram, one write and one registered read port
// depends on bfcl_pkg for the address width helper
`default_nettype none

module bfcl_ram
    import bfcl_pkg::*;
#(
    parameter int WIDTH = WORD_W,
    parameter int DEPTH = DEF_LOG_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [f_addr_w(DEPTH)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]            i_wdata,
    input  wire logic                        i_re,
    input  wire logic [f_addr_w(DEPTH)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/bit_flag_change_logger_top.sv */
// bit flag change logger: shadow compare, change events, undo history
// depends on bfcl_pkg, bfcl_ram and bit_flag_change_logger_top_defines.svh
//
// channel    direction  handshake                    payload
// command    in         start, busy                  i_func, i_record_sel, i_word_index,
//                                                    i_word_value, i_log_position
// result     out        o_strobe (one cycle)         o_kind, o_event_record, o_flag_index,
//                                                    o_flag_value, o_entry_valid, o_last
// config     in         i_cfg_valid, o_cfg_ready     i_cfg_index, i_cfg_data
//
// a word is taken when start is high and busy low; scan runs a compare state, then an emit
//   state per changed bit; undo runs a decode state, plus read and write states when its
//   shadow word is rewritten; read runs an output state; clear and an empty undo stay idle
// one event per cycle while a scan is in its emit state
// after reset a clearing pass zeroes every word of the shadow ram; busy stays high
//   meanwhile, config writes are always taken
// results cannot be stalled; each shows for exactly one cycle under o_strobe
`default_nettype none
`include "bit_flag_change_logger_top_defines.svh"

module bit_flag_change_logger_top
    import bfcl_pkg::*;
#(
    parameter int RECORDS          = DEF_RECORDS,
    parameter int WORDS_PER_RECORD = DEF_WORDS_PER_RECORD,
    parameter int LOG_DEPTH        = DEF_LOG_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // command
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_func,
    input  wire logic [REC_W-1:0]     i_record_sel,
    input  wire logic [WIDX_W-1:0]    i_word_index,
    input  wire logic [WORD_W-1:0]    i_word_value,
    input  wire logic [POS_W-1:0]     i_log_position,
    // result
    output logic                      o_strobe,
    output logic [1:0]                o_kind,
    output logic [REC_W-1:0]          o_event_record,
    output logic [FLAG_W-1:0]         o_flag_index,
    output logic                      o_flag_value,
    output logic                      o_entry_valid,
    output logic                      o_last,
    // config
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WCODE_W-1:0]   i_cfg_data
);

    // sizes
    localparam int SHW_DEPTH = RECORDS * WORDS_PER_RECORD;
    localparam int SHW_AW    = f_addr_w(SHW_DEPTH);
    localparam int LOG_AW    = f_addr_w(LOG_DEPTH);
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
    localparam int RD_W      = (CNT_W + 1 > POS_W + 1) ? CNT_W + 1 : POS_W + 1;
    localparam int WD_W      = FLAG_W - 3;

    localparam logic [SHW_AW-1:0] SHW_LAST = SHW_AW'(SHW_DEPTH - 1);
    localparam logic [SHW_AW-1:0] WPR_A    = SHW_AW'(WORDS_PER_RECORD);
    localparam logic [LOG_AW-1:0] LOG_LAST = LOG_AW'(LOG_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(LOG_DEPTH);
    localparam logic [RD_W-1:0]   RD_DEPTH = RD_W'(LOG_DEPTH);
    localparam logic [RD_W-1:0]   RD_BACK  = RD_W'(LOG_DEPTH - 1);

    // control state
    t_state             r_state, n_state;
    logic [SHW_AW-1:0]  r_clr_addr, n_clr_addr;
    t_wcode             r_width_code [CFG_REGS];
    t_wcode             n_width_code [CFG_REGS];
    logic [LOG_AW-1:0]  r_log_head, n_log_head;
    logic [CNT_W-1:0]   r_log_count, n_log_count;
    logic               r_strobe, n_strobe;

    // item context
    logic [REC_W-1:0]   r_rec, n_rec;
    t_wcode             r_wcode, n_wcode;
    logic [WORD_W-1:0]  r_word, n_word;
    logic [SHW_AW-1:0]  r_addr, n_addr;
    logic [WORD_W-1:0]  r_diff, n_diff;
    logic [WORD_W-1:0]  r_cur, n_cur;
    logic [FLAG_W-1:0]  r_flag_base, n_flag_base;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic               r_val, n_val;
    logic               r_rd_valid, n_rd_valid;

    // result payload
    t_kind              r_kind, n_kind;
    logic [REC_W-1:0]   r_out_rec, n_out_rec;
    logic [FLAG_W-1:0]  r_out_flag, n_out_flag;
    logic               r_out_value, n_out_value;
    logic               r_out_valid, n_out_valid;
    logic               r_out_last, n_out_last;

    // ram ports
    logic               shw_we, shw_re;
    logic [SHW_AW-1:0]  shw_waddr, shw_raddr;
    logic [WORD_W-1:0]  shw_wdata, shw_rdata;
    logic               log_we, log_re;
    logic [LOG_AW-1:0]  log_waddr, log_raddr;
    logic [ENTRY_W-1:0] log_wdata, log_rdata;

    // decode of the incoming command
    t_func              w_func;
    logic               w_accept;
    logic               w_undo_go;
    logic               w_scan_ok;
    logic [SHW_AW-1:0]  w_scan_addr;
    logic [LOG_AW-1:0]  w_head_dec, w_head_inc;
    logic [RD_W-1:0]    w_rd_t;
    logic [LOG_AW-1:0]  w_rd_addr;
    logic               w_rd_hit;

    // scan compare and emit
    logic [WORD_W-1:0]  w_mask, w_cur, w_diff;
    logic [WORD_W-1:0]  w_rest;
    logic [BIT_W-1:0]   w_low;
    logic [FLAG_W-1:0]  w_flag;

    // undo decode
    t_entry             w_entry;
    t_wcode             w_ucode;
    logic [WD_W-1:0]    w_wd;
    logic               w_undo_ok;
    logic [WORD_W-1:0]  w_bitsel;

    assign w_func    = t_func'(i_func);
    assign busy      = (r_state != ST_IDLE);
    assign w_accept  = start && (r_state == ST_IDLE);
    assign w_undo_go = w_accept && (w_func == FUNC_UNDO) && (r_log_count != '0);

    // scan target, dropped when record or word lies outside the shadow store
    assign w_scan_ok   = (int'(i_record_sel) < RECORDS) &&
                         (int'(i_word_index) < WORDS_PER_RECORD);
    assign w_scan_addr = SHW_AW'(i_record_sel) * WPR_A + SHW_AW'(i_word_index);

    // circular log pointers
    assign w_head_dec = (r_log_head == '0) ? LOG_LAST : r_log_head - 1'b1;
    assign w_head_inc = (r_log_head == LOG_LAST) ? '0 : r_log_head + 1'b1;

    // slot of the entry counted back from the newest; only used when it exists
    assign w_rd_hit  = int'(i_log_position) < int'(r_log_count);
    assign w_rd_t    = RD_W'(r_log_head) + RD_BACK - RD_W'(i_log_position);
    assign w_rd_addr = (w_rd_t >= RD_DEPTH) ? LOG_AW'(w_rd_t - RD_DEPTH) : LOG_AW'(w_rd_t);

    // compare against the shadow word read at accept
    assign w_mask = f_width_mask(r_wcode);
    assign w_cur  = r_word & w_mask;
    assign w_diff = w_cur ^ (shw_rdata & w_mask);

    // lowest pending change, one per cycle
    assign w_low  = f_lowest_bit(r_diff);
    assign w_rest = r_diff & (r_diff - 1'b1);
    assign w_flag = r_flag_base + FLAG_W'(w_low);

    // popped entry: locate its shadow word under the current width
    assign w_entry   = t_entry'(log_rdata);
    assign w_ucode   = r_width_code[w_entry.rec];
    assign w_wd      = WD_W'(w_entry.flag >> f_width_shift(w_ucode));
    assign w_undo_ok = (int'(w_entry.rec) < RECORDS) && (int'(w_wd) < WORDS_PER_RECORD);
    assign w_bitsel  = WORD_W'(1) << r_bit;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == SHW_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    case (w_func)
                        FUNC_SCAN: n_state = w_scan_ok ? ST_SCAN_CMP : ST_IDLE;
                        FUNC_UNDO: n_state = (r_log_count != '0) ? ST_UNDO_DEC : ST_IDLE;
                        FUNC_READ: n_state = ST_READ_OUT;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN_CMP:  n_state = (w_diff != '0) ? ST_SCAN_EMIT : ST_IDLE;
            ST_SCAN_EMIT: n_state = (w_rest == '0) ? ST_IDLE : ST_SCAN_EMIT;
            ST_UNDO_DEC:  n_state = w_undo_ok ? ST_UNDO_RD : ST_IDLE;
            ST_UNDO_RD:   n_state = ST_UNDO_WR;
            ST_UNDO_WR:   n_state = ST_IDLE;
            ST_READ_OUT:  n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // datapath, ram control and result register
    always_comb begin
        n_clr_addr   = r_clr_addr;
        n_width_code = r_width_code;
        n_log_head   = r_log_head;
        n_log_count  = r_log_count;
        n_strobe     = 1'b0;
        n_rec        = r_rec;
        n_wcode      = r_wcode;
        n_word       = r_word;
        n_addr       = r_addr;
        n_diff       = r_diff;
        n_cur        = r_cur;
        n_flag_base  = r_flag_base;
        n_bit        = r_bit;
        n_val        = r_val;
        n_rd_valid   = r_rd_valid;
        n_kind       = r_kind;
        n_out_rec    = r_out_rec;
        n_out_flag   = r_out_flag;
        n_out_value  = r_out_value;
        n_out_valid  = r_out_valid;
        n_out_last   = r_out_last;
        shw_we       = 1'b0;
        shw_waddr    = r_addr;
        shw_wdata    = w_cur;
        shw_re       = 1'b0;
        shw_raddr    = r_addr;
        log_we       = 1'b0;
        log_waddr    = r_log_head;
        log_wdata    = {r_rec, w_flag, r_cur[w_low]};
        log_re       = 1'b0;
        log_raddr    = w_head_dec;

        // width regs take valid writes below CFG_REGS; host must change them between items (unenforced)
        if (i_cfg_valid && o_cfg_ready && (int'(i_cfg_index) < CFG_REGS)) begin
            n_width_code[i_cfg_index[CFG_SEL_W-1:0]] = i_cfg_data;
        end

        case (r_state)
            ST_CLEAR: begin
                shw_we     = 1'b1;
                shw_waddr  = r_clr_addr;
                shw_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_rec       = i_record_sel;
                    n_wcode     = r_width_code[i_record_sel];
                    n_word      = i_word_value;
                    n_addr      = w_scan_addr;
                    n_flag_base = FLAG_W'(i_word_index)
                                  << f_width_shift(r_width_code[i_record_sel]);
                    n_rd_valid  = w_rd_hit;
                    case (w_func)
                        FUNC_SCAN: begin
                            shw_re    = w_scan_ok;
                            shw_raddr = w_scan_addr;
                        end
                        FUNC_UNDO: begin
                            if (r_log_count != '0) begin
                                log_re      = 1'b1;
                                log_raddr   = w_head_dec;
                                n_log_head  = w_head_dec;
                                n_log_count = r_log_count - 1'b1;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_log_count = '0;
                        end
                        FUNC_READ: begin
                            log_re    = w_rd_hit;
                            log_raddr = w_rd_addr;
                        end
                        default: begin
                            n_log_count = r_log_count;
                        end
                    endcase
                end
            end
            ST_SCAN_CMP: begin
                // new shadow goes back to the same entry now
                shw_we    = 1'b1;
                shw_waddr = r_addr;
                shw_wdata = w_cur;
                n_diff    = w_diff;
                n_cur     = w_cur;
            end
            ST_SCAN_EMIT: begin
                n_strobe    = 1'b1;
                n_kind      = KIND_CHANGE;
                n_out_rec   = r_rec;
                n_out_flag  = w_flag;
                n_out_value = r_cur[w_low];
                n_out_valid = 1'b1;
                n_out_last  = (w_rest == '0);
                n_diff      = w_rest;
                // history push, oldest dropped when full
                log_we      = 1'b1;
                log_waddr   = r_log_head;
                log_wdata   = {r_rec, w_flag, r_cur[w_low]};
                n_log_head  = w_head_inc;
                if (r_log_count != CNT_FULL) begin
                    n_log_count = r_log_count + 1'b1;
                end
            end
            ST_UNDO_DEC: begin
                n_strobe    = 1'b1;
                n_kind      = KIND_UNDO;
                n_out_rec   = w_entry.rec;
                n_out_flag  = w_entry.flag;
                n_out_value = ~w_entry.value;
                n_out_valid = 1'b1;
                n_out_last  = 1'b1;
                n_val       = ~w_entry.value;
                n_bit       = BIT_W'(w_entry.flag) & f_bit_mask(w_ucode);
                n_addr      = SHW_AW'(w_entry.rec) * WPR_A + SHW_AW'(w_wd);
            end
            ST_UNDO_RD: begin
                shw_re    = 1'b1;
                shw_raddr = r_addr;
            end
            ST_UNDO_WR: begin
                shw_we    = 1'b1;
                shw_waddr = r_addr;
                shw_wdata = r_val ? (shw_rdata | w_bitsel) : (shw_rdata & ~w_bitsel);
            end
            ST_READ_OUT: begin
                n_strobe    = 1'b1;
                n_kind      = KIND_READ;
                n_out_valid = r_rd_valid;
                n_out_last  = 1'b1;
                if (r_rd_valid) begin
                    n_out_rec   = w_entry.rec;
                    n_out_flag  = w_entry.flag;
                    n_out_value = w_entry.value;
                end else begin
                    n_out_rec   = '0;
                    n_out_flag  = '0;
                    n_out_value = 1'b0;
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_width_code <= WCODE_RESET;
            r_log_head   <= '0;
            r_log_count  <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_width_code <= n_width_code;
            r_log_head   <= n_log_head;
            r_log_count  <= n_log_count;
            r_strobe     <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rec       <= n_rec;
        r_wcode     <= n_wcode;
        r_word      <= n_word;
        r_addr      <= n_addr;
        r_diff      <= n_diff;
        r_cur       <= n_cur;
        r_flag_base <= n_flag_base;
        r_bit       <= n_bit;
        r_val       <= n_val;
        r_rd_valid  <= n_rd_valid;
        r_kind      <= n_kind;
        r_out_rec   <= n_out_rec;
        r_out_flag  <= n_out_flag;
        r_out_value <= n_out_value;
        r_out_valid <= n_out_valid;
        r_out_last  <= n_out_last;
    end

    // shadow words; one item in flight, so a write always lands before the next read
    bfcl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SHW_DEPTH)
    ) u_shadow_ram (
        .i_clk   (i_clk),
        .i_we    (shw_we),
        .i_waddr (shw_waddr),
        .i_wdata (shw_wdata),
        .i_re    (shw_re),
        .i_raddr (shw_raddr),
        .o_rdata (shw_rdata)
    );

    // change history
    bfcl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .i_clk   (i_clk),
        .i_we    (log_we),
        .i_waddr (log_waddr),
        .i_wdata (log_wdata),
        .i_re    (log_re),
        .i_raddr (log_raddr),
        .o_rdata (log_rdata)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_strobe       = r_strobe;
    assign o_kind         = r_kind;
    assign o_event_record = r_out_rec;
    assign o_flag_index   = r_out_flag;
    assign o_flag_value   = r_out_value;
    assign o_entry_valid  = r_out_valid;
    assign o_last         = r_out_last;

    // emit state only runs while changes are pending
    `BFCL_ASSERT_NOW(a_emit_pending, r_state == ST_SCAN_EMIT, r_diff != '0)
    // nothing comes out during the clearing pass
    `BFCL_ASSERT_NOW(a_quiet_clear, r_state == ST_CLEAR, !r_strobe)
    // an accepted undo on a non-empty log pops exactly one entry
    `BFCL_ASSERT_NEXT(a_undo_pop, w_undo_go, r_log_count == $past(r_log_count) - 1'b1)
    // log pointers stay within the history
    `BFCL_ASSERT_NOW(a_count_bound, 1'b1, int'(r_log_count) <= LOG_DEPTH)
    `BFCL_ASSERT_NOW(a_head_bound, 1'b1, int'(r_log_head) < LOG_DEPTH)

endmodule

`default_nettype wire

/* tb/sv/bit_flag_change_logger_top_tb.sv */
// self-checking testbench for bit_flag_change_logger_top: directed and random commands,
// width register changes between phases, every result compared with a built-in predictor
// depends on bfcl_pkg and the design files of bit_flag_change_logger_top
`timescale 1ns / 100ps

import bfcl_pkg::*;

// one result word as seen on the result ports
typedef struct packed {
    logic [1:0]        kind;
    logic [REC_W-1:0]  rec;
    logic [FLAG_W-1:0] flag;
    logic              value;
    logic              valid;
    logic              last;
} t_flag_event;

// shadow words, change history and width codes, plus the events still owed by the block
class flag_log_tracker;
    logic [WORD_W-1:0] shadow [DEF_RECORDS*DEF_WORDS_PER_RECORD];
    t_entry            history [DEF_LOG_DEPTH];
    int unsigned       hist_head;
    int unsigned       hist_count;
    t_wcode            width_code [CFG_REGS];
    t_flag_event       pending_events [$];
    int unsigned       mismatches;

    function new();
        foreach (shadow[i]) shadow[i] = '0;
        foreach (history[i]) history[i] = '0;
        hist_head  = 0;
        hist_count = 0;
        width_code = WCODE_RESET;
        mismatches = 0;
    endfunction

    function int unsigned word_bits(logic [REC_W-1:0] rec);
        case (width_code[rec])
            WCODE_8:  return 8;
            WCODE_16: return 16;
            default:  return 32;
        endcase
    endfunction

    function logic [WORD_W-1:0] stored_word(logic [REC_W-1:0] rec, logic [WIDX_W-1:0] idx);
        return shadow[rec*DEF_WORDS_PER_RECORD + idx];
    endfunction

    function void set_width(int idx, t_wcode code);
        width_code[idx] = code;
    endfunction

    function void owe(logic [1:0] kind, logic [REC_W-1:0] rec, logic [FLAG_W-1:0] flag,
                      logic value, logic valid);
        t_flag_event ev;
        ev.kind  = kind;
        ev.rec   = rec;
        ev.flag  = flag;
        ev.value = value;
        ev.valid = valid;
        ev.last  = 1'b0;
        pending_events.push_back(ev);
    endfunction

    // works out the events caused by one accepted command word
    function void note_command(t_func func, logic [REC_W-1:0] rec, logic [WIDX_W-1:0] idx,
                               logic [WORD_W-1:0] value, logic [POS_W-1:0] pos);
        int unsigned       n_before;
        int unsigned       w;
        int unsigned       addr;
        int unsigned       wd;
        int unsigned       bitpos;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] cur;
        logic [WORD_W-1:0] diff;
        logic [FLAG_W-1:0] flag;
        t_entry            ent;
        t_flag_event       tail;
        n_before = pending_events.size();
        case (func)
            FUNC_SCAN: begin
                w    = word_bits(rec);
                mask = (w >= 32) ? '1 : ((32'd1 << w) - 32'd1);
                addr = rec*DEF_WORDS_PER_RECORD + idx;
                cur  = value & mask;
                diff = cur ^ (shadow[addr] & mask);
                for (int b = 0; b < w; b++) begin
                    if (diff[b]) begin
                        flag = FLAG_W'(idx*w + b);
                        owe(KIND_CHANGE, rec, flag, cur[b], 1'b1);
                        ent.rec   = rec;
                        ent.flag  = flag;
                        ent.value = cur[b];
                        history[hist_head] = ent;
                        hist_head = (hist_head + 1) % DEF_LOG_DEPTH;
                        if (hist_count < DEF_LOG_DEPTH) hist_count++;
                    end
                end
                shadow[addr] = cur;
            end
            FUNC_UNDO: begin
                if (hist_count != 0) begin
                    hist_head = (hist_head + DEF_LOG_DEPTH - 1) % DEF_LOG_DEPTH;
                    hist_count--;
                    ent    = history[hist_head];
                    w      = word_bits(ent.rec);
                    wd     = ent.flag / w;
                    bitpos = ent.flag % w;
                    // a flag beyond the record under the current width leaves the shadow alone
                    if (wd < DEF_WORDS_PER_RECORD)
                        shadow[ent.rec*DEF_WORDS_PER_RECORD + wd][bitpos] = ~ent.value;
                    owe(KIND_UNDO, ent.rec, ent.flag, ~ent.value, 1'b1);
                end
            end
            FUNC_CLEAR: begin
                hist_count = 0;
            end
            default: begin
                if (pos < hist_count) begin
                    ent = history[(hist_head + DEF_LOG_DEPTH - 1 - pos) % DEF_LOG_DEPTH];
                    owe(KIND_READ, ent.rec, ent.flag, ent.value, 1'b1);
                end else begin
                    owe(KIND_READ, '0, '0, 1'b0, 1'b0);
                end
            end
        endcase
        if (pending_events.size() > n_before) begin
            tail = pending_events.pop_back();
            tail.last = 1'b1;
            pending_events.push_back(tail);
        end
    endfunction

    function void check_event(t_flag_event got);
        t_flag_event want;
        if (pending_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: kind %0d rec %0d flag %0d value %0d valid %0d last %0d",
                         got.kind, got.rec, got.flag, got.value, got.valid, got.last);
            return;
        end
        want = pending_events.pop_front();
        if (got.kind !== want.kind || got.rec !== want.rec || got.flag !== want.flag ||
            got.value !== want.value || got.valid !== want.valid || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected kind %0d rec %0d flag %0d value %0d valid %0d last %0d",
                         want.kind, want.rec, want.flag, want.value, want.valid, want.last);
                $display("          got      kind %0d rec %0d flag %0d value %0d valid %0d last %0d",
                         got.kind, got.rec, got.flag, got.value, got.valid, got.last);
            end
        end
    endfunction
endclass

module bit_flag_change_logger_top_tb;

    // width code three is not named by the package; the block treats it as 32 bits
    localparam t_wcode WCODE_SPARE = 2'd3;

    // indexes that scans keep coming back to, so that the shadow words change a little
    localparam logic [WIDX_W-1:0] HOT_IDX [4] = '{10'd0, 10'd1, 10'd2, 10'd1023};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           i_func = '0;
    logic [REC_W-1:0]     i_record_sel = '0;
    logic [WIDX_W-1:0]    i_word_index = '0;
    logic [WORD_W-1:0]    i_word_value = '0;
    logic [POS_W-1:0]     i_log_position = '0;
    logic                 o_strobe;
    logic [1:0]           o_kind;
    logic [REC_W-1:0]     o_event_record;
    logic [FLAG_W-1:0]    o_flag_index;
    logic                 o_flag_value;
    logic                 o_entry_valid;
    logic                 o_last;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WCODE_W-1:0]   i_cfg_data = '0;

    // when set, commands follow each other with no gap
    bit burst_mode = 1'b0;

    flag_log_tracker tracker = new();

    bit_flag_change_logger_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_record_sel   (i_record_sel),
        .i_word_index   (i_word_index),
        .i_word_value   (i_word_value),
        .i_log_position (i_log_position),
        .o_strobe       (o_strobe),
        .o_kind         (o_kind),
        .o_event_record (o_event_record),
        .o_flag_index   (o_flag_index),
        .o_flag_value   (o_flag_value),
        .o_entry_valid  (o_entry_valid),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // results cannot be held off: every strobed word is taken at the edge that ends it
    always @(posedge i_clk) begin : result_monitor
        t_flag_event got;
        if (i_rst_n && o_strobe) begin
            got.kind  = o_kind;
            got.rec   = o_event_record;
            got.flag  = o_flag_index;
            got.value = o_flag_value;
            got.valid = o_entry_valid;
            got.last  = o_last;
            tracker.check_event(got);
        end
    end

    // hands one command word over; start stays high into the next word when there is no gap
    task automatic send_command(input t_func func, input logic [REC_W-1:0] rec,
                                input logic [WIDX_W-1:0] idx, input logic [WORD_W-1:0] value,
                                input logic [POS_W-1:0] pos);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_func         <= func;
        i_record_sel   <= rec;
        i_word_index   <= idx;
        i_word_value   <= value;
        i_log_position <= pos;
        do @(posedge i_clk); while (busy !== 1'b0);
        // noted here, in order, so the next word is built from up-to-date shadow state
        tracker.note_command(func, rec, idx, value, pos);
    endtask

    // writes all four width registers back to back
    task automatic write_widths(input t_wcode codes [CFG_REGS]);
        for (int i = 0; i < CFG_REGS; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= codes[i];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            tracker.set_width(i, codes[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // drains every owed result, then leaves room for a command that causes none
    task automatic settle();
        int unsigned guard;
        start <= 1'b0;
        guard = 0;
        @(posedge i_clk);
        while (tracker.pending_events.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        // anything still owed here never came
        if (tracker.pending_events.size() != 0 && tracker.mismatches < 10)
            $display("missing results: %0d expected words never came",
                     tracker.pending_events.size());
        tracker.mismatches += tracker.pending_events.size();
        tracker.pending_events.delete();
        repeat (40) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        int unsigned       pick;
        int unsigned       w;
        int unsigned       nbits;
        t_func             func;
        logic [REC_W-1:0]  rec;
        logic [WIDX_W-1:0] idx;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] mask;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            // unused fields carry noise
            rec   = REC_W'($urandom);
            idx   = WIDX_W'($urandom);
            value = $urandom;
            pick  = $urandom_range(0, 99);
            if (pick < 55) begin
                func = FUNC_SCAN;
                if ($urandom_range(0, 3) != 0) idx = HOT_IDX[2'($urandom_range(0, 3))];
                w    = tracker.word_bits(rec);
                mask = (w >= 32) ? '1 : ((32'd1 << w) - 32'd1);
                case ($urandom_range(0, 9))
                    0: ;    // whole new word
                    1: begin
                        // unchanged word, high bits beyond the width may wiggle
                        value = tracker.stored_word(rec, idx) | (value & ~mask);
                    end
                    default: begin
                        // a few toggled flags, now and then one above the width
                        value = tracker.stored_word(rec, idx);
                        nbits = $urandom_range(1, 3);
                        for (int k = 0; k < nbits; k++) begin
                            if ($urandom_range(0, 9) == 0)
                                value[BIT_W'($urandom_range(0, 31))] ^= 1'b1;
                            else
                                value[BIT_W'($urandom_range(0, w-1))] ^= 1'b1;
                        end
                    end
                endcase
            end else if (pick < 70) begin
                func = FUNC_UNDO;
            end else if (pick < 75) begin
                func = FUNC_CLEAR;
            end else begin
                func = FUNC_READ;
            end
            send_command(func, rec, idx, value, POS_W'($urandom_range(0, 15)));
        end
    endtask

    initial begin : stimulus
        t_wcode codes [CFG_REGS];

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // busy covers the clearing pass over the shadow ram
        do @(posedge i_clk); while (busy !== 1'b0);

        // directed part under the reset widths 32, 32, 32, 8
        send_command(FUNC_READ,  2'd0, 10'd0,    32'h0000_0000, 4'd0);  // read of an empty log
        send_command(FUNC_UNDO,  2'd0, 10'd0,    32'h0000_0000, 4'd0);  // undo with nothing logged
        send_command(FUNC_CLEAR, 2'd0, 10'd0,    32'h0000_0000, 4'd0);
        send_command(FUNC_SCAN,  2'd0, 10'd0,    32'hffff_ffff, 4'd0);  // every bit, log overflows
        send_command(FUNC_SCAN,  2'd0, 10'd0,    32'hffff_ffff, 4'd0);  // no change
        send_command(FUNC_READ,  2'd0, 10'd0,    32'h0000_0000, 4'd0);
        send_command(FUNC_READ,  2'd0, 10'd0,    32'h0000_0000, 4'd15);
        send_command(FUNC_UNDO,  2'd0, 10'd0,    32'h0000_0000, 4'd0);
        send_command(FUNC_SCAN,  2'd0, 10'd0,    32'hffff_ffff, 4'd0);
        send_command(FUNC_SCAN,  2'd3, 10'd1023, 32'hffff_ff00, 4'd0);  // only bits above the 8-bit width set
        send_command(FUNC_SCAN,  2'd3, 10'd1023, 32'h0000_00a5, 4'd0);
        send_command(FUNC_SCAN,  2'd1, 10'd1023, 32'h8000_0001, 4'd0);  // highest flag index
        send_command(FUNC_SCAN,  2'd2, 10'd682,  32'h5555_5555, 4'd0);
        send_command(FUNC_READ,  2'd0, 10'd0,    32'h0000_0000, 4'd4);
        send_command(FUNC_CLEAR, 2'd0, 10'd0,    32'h0000_0000, 4'd0);
        send_command(FUNC_READ,  2'd0, 10'd0,    32'h0000_0000, 4'd0);
        send_command(FUNC_UNDO,  2'd0, 10'd0,    32'h0000_0000, 4'd0);  // empty after clear
        send_command(FUNC_SCAN,  2'd1, 10'd1023, 32'h0000_0001, 4'd0);
        settle();

        // record 1 shrinks to 8 bits, so its logged flag 32767 falls outside the record
        write_widths('{WCODE_SPARE, WCODE_8, WCODE_16, WCODE_32});
        send_command(FUNC_UNDO,  2'd0, 10'd0,    32'h0000_0000, 4'd0);  // no write-back, shadow kept
        send_command(FUNC_SCAN,  2'd1, 10'd1023, 32'h0000_00ff, 4'd0);
        send_command(FUNC_SCAN,  2'd0, 10'd5,    32'hdead_beef, 4'd0);  // width code three
        send_command(FUNC_SCAN,  2'd2, 10'd1,    32'hffff_1234, 4'd0);
        send_command(FUNC_SCAN,  2'd3, 10'd341,  32'h8000_0000, 4'd0);
        send_command(FUNC_READ,  2'd0, 10'd0,    32'h0000_0000, 4'd3);
        send_command(FUNC_UNDO,  2'd0, 10'd0,    32'h0000_0000, 4'd0);
        settle();

        // random phases, first each width uniform across all records, then mixed widths
        for (int phase = 0; phase < 6; phase++) begin
            foreach (codes[i]) begin
                case (phase)
                    0:       codes[i] = WCODE_8;
                    1:       codes[i] = WCODE_32;
                    2:       codes[i] = WCODE_SPARE;
                    3:       codes[i] = WCODE_16;
                    default: codes[i] = t_wcode'($urandom_range(0, 3));
                endcase
            end
            write_widths(codes);
            run_random(80);
            settle();
        end

        if (tracker.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin : watchdog
        #3_200_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/bfcl_pkg.sv
design/bfcl_ram.sv
design/bit_flag_change_logger_top.sv
tb/sv/bit_flag_change_logger_top_tb.sv
